/* rtl/bbcm_pkg.sv */
// Shared constants, codes and handshake types for the block buffer cache manager.
// No dependencies.
`timescale 1ns / 1ps

package bbcm_pkg;

   localparam int NUM_SLOTS  = 16;
   localparam int NUM_CHAINS = 4;
   localparam int BLOCK_BITS = 16;

   localparam int IDX_W   = $clog2(NUM_SLOTS);
   localparam int PTR_W   = IDX_W + 1;
   localparam int CHAIN_W = $clog2(NUM_CHAINS);
   localparam int FLAG_W  = 6;

   typedef logic [IDX_W-1:0]      idx_type;
   typedef logic [PTR_W-1:0]      ptr_type;
   typedef logic [BLOCK_BITS-1:0] block_type;
   typedef logic [FLAG_W-1:0]     flags_type;
   typedef logic [CHAIN_W-1:0]    chain_type;

   localparam ptr_type NIL = ptr_type'(NUM_SLOTS);

   // status bit positions
   localparam int F_L = 0;
   localparam int F_V = 1;
   localparam int F_D = 2;
   localparam int F_K = 3;
   localparam int F_W = 4;
   localparam int F_O = 5;

   localparam logic [1:0] OP_GET     = 2'd0;
   localparam logic [1:0] OP_RELEASE = 2'd1;
   localparam logic [1:0] OP_SET     = 2'd2;
   localparam logic [1:0] OP_CLEAR   = 2'd3;

   localparam logic [3:0] KIND_HIT         = 4'd0;
   localparam logic [3:0] KIND_ALLOCATED   = 4'd1;
   localparam logic [3:0] KIND_SLEEP_BUSY  = 4'd2;
   localparam logic [3:0] KIND_SLEEP_EMPTY = 4'd3;
   localparam logic [3:0] KIND_WRITEBACK   = 4'd4;
   localparam logic [3:0] KIND_FREED_TAIL  = 4'd5;
   localparam logic [3:0] KIND_FREED_HEAD  = 4'd6;
   localparam logic [3:0] KIND_STATUS      = 4'd7;
   localparam logic [3:0] KIND_NOT_FOUND   = 4'd8;

   localparam logic [2:0] ACT_HIT_LOCKED = 3'd0;
   localparam logic [2:0] ACT_HIT_TAKE   = 3'd1;
   localparam logic [2:0] ACT_NO_FREE    = 3'd2;
   localparam logic [2:0] ACT_WRITEBACK  = 3'd3;
   localparam logic [2:0] ACT_ALLOCATE   = 3'd4;
   localparam logic [2:0] ACT_RELEASE    = 3'd5;
   localparam logic [2:0] ACT_NOT_FOUND  = 3'd6;
   localparam logic [2:0] ACT_STATUS     = 3'd7;

   typedef struct packed {
      logic       load;
      logic       walk;
      logic       act_en;
      logic [2:0] act;
   } cmd_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic       search_done;
      logic       hit;
      logic       hit_locked;
      logic       free_empty;
      logic       head_delayed;
      logic       last;
   } status_type;

endpackage

/* rtl/bbcm_datapath.sv */
// Buffer pool datapath: block/status store, hash chains, free list and result register.
// Depends on bbcm_pkg; driven by bbcm_ctrl through cmd_type.
`timescale 1ns / 1ps

module bbcm_datapath import bbcm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   input  logic [1:0] req_opcode,
   input  block_type  req_block_number,
   input  flags_type  req_status_mask,
   output status_type status,
   output logic [3:0] rsp_result_kind,
   output idx_type    rsp_buffer_index,
   output block_type  rsp_result_block,
   output flags_type  rsp_buffer_status,
   output logic       rsp_wake_block_waiters,
   output logic       rsp_last
);

   block_type blk_ff    [NUM_SLOTS];
   block_type blk_in    [NUM_SLOTS];
   flags_type flags_ff  [NUM_SLOTS];
   flags_type flags_in  [NUM_SLOTS];
   ptr_type   cnext_ff  [NUM_SLOTS];
   ptr_type   cnext_in  [NUM_SLOTS];
   ptr_type   cprev_ff  [NUM_SLOTS];
   ptr_type   cprev_in  [NUM_SLOTS];
   ptr_type   cfirst_ff [NUM_CHAINS];
   ptr_type   cfirst_in [NUM_CHAINS];
   ptr_type   clast_ff  [NUM_CHAINS];
   ptr_type   clast_in  [NUM_CHAINS];
   ptr_type   fnext_ff  [NUM_SLOTS];
   ptr_type   fnext_in  [NUM_SLOTS];
   ptr_type   fprev_ff  [NUM_SLOTS];
   ptr_type   fprev_in  [NUM_SLOTS];
   ptr_type   ffirst_ff, ffirst_in;
   ptr_type   flast_ff, flast_in;

   logic [1:0] op_ff, op_in;
   block_type  req_blk_ff, req_blk_in;
   flags_type  mask_ff, mask_in;
   ptr_type    cur_ff, cur_in;

   logic [3:0] kind_ff, kind_in;
   idx_type    oidx_ff, oidx_in;
   block_type  oblk_ff, oblk_in;
   flags_type  ostat_ff, ostat_in;
   logic       wake_ff, wake_in;
   logic       last_ff, last_in;

   idx_type   cur_idx, head_idx, sel, ui;
   ptr_type   p, n, lt;
   chain_type c, oc;
   logic      unlink_en, use_nil, match;

   assign cur_idx  = cur_ff[IDX_W-1:0];
   assign head_idx = ffirst_ff[IDX_W-1:0];
   assign match    = blk_ff[cur_idx] == req_blk_ff;

   assign status.opcode       = op_ff;
   assign status.search_done  = (cur_ff == NIL) || match;
   assign status.hit          = (cur_ff != NIL) && match;
   assign status.hit_locked   = flags_ff[cur_idx][F_L];
   assign status.free_empty   = ffirst_ff == NIL;
   assign status.head_delayed = flags_ff[head_idx][F_D];
   assign status.last         = last_ff;

   always_comb begin
      blk_in    = blk_ff;
      flags_in  = flags_ff;
      cnext_in  = cnext_ff;
      cprev_in  = cprev_ff;
      cfirst_in = cfirst_ff;
      clast_in  = clast_ff;
      fnext_in  = fnext_ff;
      fprev_in  = fprev_ff;
      ffirst_in = ffirst_ff;
      flast_in  = flast_ff;
      op_in      = op_ff;
      req_blk_in = req_blk_ff;
      mask_in    = mask_ff;
      cur_in     = cur_ff;
      kind_in  = kind_ff;
      oidx_in  = oidx_ff;
      oblk_in  = oblk_ff;
      ostat_in = ostat_ff;
      wake_in  = wake_ff;
      last_in  = last_ff;
      p = NIL;
      n = NIL;
      lt = NIL;
      c = req_blk_ff[CHAIN_W-1:0];
      oc = '0;
      sel = cur_idx;
      use_nil = 1'b0;
      unlink_en = 1'b0;
      ui = cur_idx;

      if (cmd.load) begin
         op_in      = req_opcode;
         req_blk_in = req_block_number;
         mask_in    = req_status_mask;
         cur_in     = cfirst_ff[req_block_number[CHAIN_W-1:0]];
      end
      if (cmd.walk) begin
         cur_in = cnext_ff[cur_idx];
      end

      if (cmd.act_en) begin
         case (cmd.act)
            ACT_HIT_TAKE, ACT_RELEASE: begin
               unlink_en = 1'b1;
               ui = cur_idx;
            end
            ACT_WRITEBACK, ACT_ALLOCATE: begin
               unlink_en = 1'b1;
               ui = head_idx;
            end
            default: unlink_en = 1'b0;
         endcase
      end

      // take the buffer off the free list first
      if (unlink_en && (ffirst_in == {1'b0, ui} || fprev_in[ui] != NIL)) begin
         p = fprev_in[ui];
         n = fnext_in[ui];
         if (p == NIL) ffirst_in = n;
         else fnext_in[p[IDX_W-1:0]] = n;
         if (n == NIL) flast_in = p;
         else fprev_in[n[IDX_W-1:0]] = p;
         fnext_in[ui] = NIL;
         fprev_in[ui] = NIL;
      end

      if (cmd.act_en) begin
         wake_in = 1'b0;
         last_in = 1'b1;
         unique case (cmd.act)
            ACT_HIT_LOCKED: begin
               flags_in[cur_idx][F_W] = 1'b1;
               kind_in = KIND_SLEEP_BUSY;
            end
            ACT_HIT_TAKE: begin
               flags_in[cur_idx][F_L] = 1'b1;
               kind_in = KIND_HIT;
            end
            ACT_NO_FREE: begin
               use_nil = 1'b1;
               kind_in = KIND_SLEEP_EMPTY;
            end
            ACT_WRITEBACK: begin
               sel = head_idx;
               flags_in[head_idx][F_D] = 1'b0;
               flags_in[head_idx][F_L] = 1'b1;
               flags_in[head_idx][F_K] = 1'b1;
               flags_in[head_idx][F_O] = 1'b1;
               kind_in = KIND_WRITEBACK;
               last_in = 1'b0;
            end
            ACT_ALLOCATE: begin
               sel = head_idx;
               flags_in[head_idx][F_L] = 1'b1;
               flags_in[head_idx][F_V] = 1'b0;
               // leave the old chain
               oc = blk_ff[head_idx][CHAIN_W-1:0];
               if (cfirst_in[oc] == ffirst_ff || cprev_in[head_idx] != NIL) begin
                  p = cprev_in[head_idx];
                  n = cnext_in[head_idx];
                  if (p == NIL) cfirst_in[oc] = n;
                  else cnext_in[p[IDX_W-1:0]] = n;
                  if (n == NIL) clast_in[oc] = p;
                  else cprev_in[n[IDX_W-1:0]] = p;
               end
               blk_in[head_idx] = req_blk_ff;
               lt = clast_in[c];
               cnext_in[head_idx] = NIL;
               cprev_in[head_idx] = lt;
               if (lt == NIL) cfirst_in[c] = ffirst_ff;
               else cnext_in[lt[IDX_W-1:0]] = ffirst_ff;
               clast_in[c] = ffirst_ff;
               kind_in = KIND_ALLOCATED;
            end
            ACT_RELEASE: begin
               wake_in = flags_ff[cur_idx][F_W];
               flags_in[cur_idx][F_W] = 1'b0;
               if (flags_ff[cur_idx][F_V] && !flags_ff[cur_idx][F_O]) begin
                  lt = flast_in;
                  fnext_in[cur_idx] = NIL;
                  fprev_in[cur_idx] = lt;
                  if (lt == NIL) ffirst_in = cur_ff;
                  else fnext_in[lt[IDX_W-1:0]] = cur_ff;
                  flast_in = cur_ff;
                  kind_in = KIND_FREED_TAIL;
               end else begin
                  flags_in[cur_idx][F_O] = 1'b0;
                  lt = ffirst_in;
                  fprev_in[cur_idx] = NIL;
                  fnext_in[cur_idx] = lt;
                  if (lt == NIL) flast_in = cur_ff;
                  else fprev_in[lt[IDX_W-1:0]] = cur_ff;
                  ffirst_in = cur_ff;
                  kind_in = KIND_FREED_HEAD;
               end
               flags_in[cur_idx][F_L] = 1'b0;
            end
            ACT_NOT_FOUND: begin
               use_nil = 1'b1;
               kind_in = KIND_NOT_FOUND;
            end
            ACT_STATUS: begin
               if (op_ff == OP_SET) flags_in[cur_idx] = flags_ff[cur_idx] | mask_ff;
               else flags_in[cur_idx] = flags_ff[cur_idx] & ~mask_ff;
               kind_in = KIND_STATUS;
            end
            default: kind_in = KIND_NOT_FOUND;
         endcase
         if (use_nil) begin
            oidx_in  = '0;
            oblk_in  = req_blk_ff;
            ostat_in = '0;
         end else begin
            oidx_in  = sel;
            oblk_in  = blk_in[sel];
            ostat_in = flags_in[sel];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_SLOTS; k++) begin
            blk_ff[k]   <= '0;
            flags_ff[k] <= '0;
            cnext_ff[k] <= NIL;
            cprev_ff[k] <= NIL;
            fnext_ff[k] <= (k + 1 < NUM_SLOTS) ? ptr_type'(k + 1) : NIL;
            fprev_ff[k] <= (k > 0) ? ptr_type'(k - 1) : NIL;
         end
         for (int k = 0; k < NUM_CHAINS; k++) begin
            cfirst_ff[k] <= NIL;
            clast_ff[k]  <= NIL;
         end
         ffirst_ff <= '0;
         flast_ff  <= ptr_type'(NUM_SLOTS - 1);
         cur_ff    <= NIL;
         last_ff   <= 1'b1;
      end else begin
         blk_ff    <= blk_in;
         flags_ff  <= flags_in;
         cnext_ff  <= cnext_in;
         cprev_ff  <= cprev_in;
         fnext_ff  <= fnext_in;
         fprev_ff  <= fprev_in;
         cfirst_ff <= cfirst_in;
         clast_ff  <= clast_in;
         ffirst_ff <= ffirst_in;
         flast_ff  <= flast_in;
         cur_ff    <= cur_in;
         last_ff   <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      req_blk_ff <= req_blk_in;
      mask_ff    <= mask_in;
      kind_ff    <= kind_in;
      oidx_ff    <= oidx_in;
      oblk_ff    <= oblk_in;
      ostat_ff   <= ostat_in;
      wake_ff    <= wake_in;
   end

   assign rsp_result_kind        = kind_ff;
   assign rsp_buffer_index       = oidx_ff;
   assign rsp_result_block       = oblk_ff;
   assign rsp_buffer_status      = ostat_ff;
   assign rsp_wake_block_waiters = wake_ff;
   assign rsp_last               = last_ff;

endmodule

/* rtl/bbcm_ctrl.sv */
// Sequencer for the buffer cache: chain walk, allocation loop and result handshake.
// Depends on bbcm_pkg; drives bbcm_datapath through cmd_type.
`timescale 1ns / 1ps

module bbcm_ctrl import bbcm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SEARCH = 2'd1;
   localparam logic [1:0] ST_ALLOC  = 2'd2;
   localparam logic [1:0] ST_EMIT   = 2'd3;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (!status.search_done) begin
               cmd.walk = 1'b1;
            end else begin
               cmd.act_en = 1'b1;
               state_in   = ST_EMIT;
               case (status.opcode)
                  OP_GET: begin
                     if (!status.hit) begin
                        cmd.act_en = 1'b0;
                        state_in   = ST_ALLOC;
                     end else if (status.hit_locked) cmd.act = ACT_HIT_LOCKED;
                     else cmd.act = ACT_HIT_TAKE;
                  end
                  OP_RELEASE: begin
                     cmd.act = (status.hit && status.hit_locked) ? ACT_RELEASE : ACT_NOT_FOUND;
                  end
                  default: cmd.act = status.hit ? ACT_STATUS : ACT_NOT_FOUND;
               endcase
            end
         end
         ST_ALLOC: begin
            cmd.act_en = 1'b1;
            state_in   = ST_EMIT;
            if (status.free_empty) cmd.act = ACT_NO_FREE;
            else if (status.head_delayed) cmd.act = ACT_WRITEBACK;
            else cmd.act = ACT_ALLOCATE;
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            // a writeback result is followed by another look at the free head
            if (rsp_ready) state_in = status.last ? ST_IDLE : ST_ALLOC;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/block_buffer_cache_manager.sv */
// Set, clear, release and get hits walk the hash chain one buffer per cycle, then register the result;
// a get miss passes through the allocation state first, and each writeback repeats that state.
// One transaction at a time: a new request is taken only after the final result is accepted.
// The free-head loop alternates allocation and result states until an allocation or no-free result.
// Reset (synchronous): all buffers unhashed, invalid and on the free list in index order.
`timescale 1ns / 1ps

module block_buffer_cache_manager import bbcm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_opcode,
   input  block_type  req_block_number,
   input  flags_type  req_status_mask,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [3:0] rsp_result_kind,
   output idx_type    rsp_buffer_index,
   output block_type  rsp_result_block,
   output flags_type  rsp_buffer_status,
   output logic       rsp_wake_block_waiters,
   output logic       rsp_last
);

   cmd_type    cmd;
   status_type status;

   bbcm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bbcm_datapath u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .req_opcode             (req_opcode),
      .req_block_number       (req_block_number),
      .req_status_mask        (req_status_mask),
      .status                 (status),
      .rsp_result_kind        (rsp_result_kind),
      .rsp_buffer_index       (rsp_buffer_index),
      .rsp_result_block       (rsp_result_block),
      .rsp_buffer_status      (rsp_buffer_status),
      .rsp_wake_block_waiters (rsp_wake_block_waiters),
      .rsp_last               (rsp_last)
   );

endmodule

/* rtl/bbcm_checker.sv */
// Port-level checks for block_buffer_cache_manager, attached by bind.
// Depends on bbcm_pkg.
`timescale 1ns / 1ps

module bbcm_checker import bbcm_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [3:0] rsp_result_kind,
   input logic       rsp_wake_block_waiters,
   input logic       rsp_last
);

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_kind))
      else $error("result changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid)
      else $error("new transaction taken while a result is pending");

   a_writeback_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KIND_WRITEBACK |-> !rsp_last)
      else $error("writeback result marked last");

   a_wake_only_release: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_wake_block_waiters |->
         rsp_result_kind == KIND_FREED_TAIL || rsp_result_kind == KIND_FREED_HEAD)
      else $error("wake outside a release");

   a_more_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> !req_ready)
      else $error("input taken before the final result");

endmodule

bind block_buffer_cache_manager bbcm_checker u_bbcm_checker (
   .clock                  (clock),
   .reset                  (reset),
   .req_ready              (req_ready),
   .rsp_valid              (rsp_valid),
   .rsp_ready              (rsp_ready),
   .rsp_result_kind        (rsp_result_kind),
   .rsp_wake_block_waiters (rsp_wake_block_waiters),
   .rsp_last               (rsp_last)
);
